[rtl/assert_macros.svh]
// Assertion helpers for the checker file dad_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DAD_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define DAD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/dad_pkg.sv]
package dad_pkg;

  localparam int unsigned YEAR_W      = 14;
  localparam int unsigned MONTH_W     = 4;
  localparam int unsigned DAY_W       = 5;
  localparam int unsigned WDAY_W      = 3;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 14;
  localparam int unsigned YMOD_W      = 9;
  localparam int unsigned RED_W       = 14;
  localparam int unsigned RED_SHIFT_W = 3;
  localparam int unsigned WSUM_W      = 10;

  localparam int unsigned YEAR_MOD   = 400;
  localparam int unsigned WEEK_LEN   = 7;
  localparam int unsigned MONTHS     = 12;
  localparam int unsigned FEB        = 2;
  localparam int unsigned FEB_LEAP   = 29;
  localparam int unsigned FEB_COMMON = 28;

  // First shift of the compare-subtract reducer for each modulus.
  localparam int unsigned RED_START_YEAR = 5;
  localparam int unsigned RED_START_WEEK = 6;

  localparam logic [YEAR_W-1:0]  BASE_YEAR_RST  = YEAR_W'(2000);
  localparam logic [MONTH_W-1:0] BASE_MONTH_RST = MONTH_W'(1);
  localparam logic [DAY_W-1:0]   BASE_DAY_RST   = DAY_W'(1);

  localparam logic [DAY_W-1:0] MONTH_DAYS [MONTHS] =
    '{5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31};

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BASE_YEAR  = 2'd0,
    CFG_BASE_MONTH = 2'd1,
    CFG_BASE_DAY   = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic                   load;
    logic                   red_en;
    logic                   red_week;
    logic [RED_SHIFT_W-1:0] red_shift;
    logic                   ymod_ld;
    logic                   walk;
    logic                   wsum;
  } dp_cmd_t;

  typedef struct packed {
    logic walk_done;
  } dp_sts_t;

  function automatic logic [DAY_W-1:0] days_in(input logic [MONTH_W-1:0] m, input logic leap);
    logic [DAY_W-1:0] len;
    priority if (m == MONTH_W'(FEB)) begin
      len = leap ? DAY_W'(FEB_LEAP) : DAY_W'(FEB_COMMON);
    end else if (m != '0 && m <= MONTH_W'(MONTHS)) begin
      len = MONTH_DAYS[m - MONTH_W'(1)];
    end else begin
      len = 5'd31;
    end
    return len;
  endfunction

  // Month term of the weekday sum, reduced mod 7; January and February count
  // as months 13 and 14.
  function automatic logic [WDAY_W-1:0] month_code(input logic [MONTH_W-1:0] m);
    logic [WDAY_W-1:0] c;
    unique case (m)
      4'd1:    c = 3'd6;
      4'd2:    c = 3'd2;
      4'd3:    c = 3'd1;
      4'd4:    c = 3'd4;
      4'd5:    c = 3'd6;
      4'd6:    c = 3'd2;
      4'd7:    c = 3'd4;
      4'd8:    c = 3'd0;
      4'd9:    c = 3'd3;
      4'd10:   c = 3'd5;
      4'd11:   c = 3'd1;
      4'd12:   c = 3'd3;
      default: c = 3'd0;
    endcase
    return c;
  endfunction

endpackage

[rtl/dad_if.sv]
interface dad_in_if #(
  parameter int unsigned OFFSET_BITS = 16
) ();
  logic                   valid;
  logic                   ready;
  logic [OFFSET_BITS-1:0] day_offset;

  modport source (output valid, output day_offset, input ready);
  modport sink   (input valid, input day_offset, output ready);
endinterface

interface dad_out_if ();
  logic                          valid;
  logic                          ready;
  logic [dad_pkg::YEAR_W-1:0]    result_year;
  logic [dad_pkg::MONTH_W-1:0]   result_month;
  logic [dad_pkg::DAY_W-1:0]     result_day;
  logic [dad_pkg::WDAY_W-1:0]    weekday;

  modport source (output valid, output result_year, output result_month,
                  output result_day, output weekday, input ready);
  modport sink   (input valid, input result_year, input result_month,
                  input result_day, input weekday, output ready);
endinterface

[rtl/dad_dpath.sv]
module dad_dpath #(
  parameter int unsigned OFFSET_BITS = 16
) (
  input  logic                             clk_i,
  input  dad_pkg::dp_cmd_t                 cmd_i,
  output dad_pkg::dp_sts_t                 sts_o,
  input  logic [dad_pkg::YEAR_W-1:0]       base_year_i,
  input  logic [dad_pkg::MONTH_W-1:0]      base_month_i,
  input  logic [dad_pkg::DAY_W-1:0]        base_day_i,
  input  logic [OFFSET_BITS-1:0]           day_offset_i,
  output logic [dad_pkg::YEAR_W-1:0]       year_o,
  output logic [dad_pkg::MONTH_W-1:0]      month_o,
  output logic [dad_pkg::DAY_W-1:0]        day_o,
  output logic [dad_pkg::WDAY_W-1:0]       wday_o
);

  localparam int unsigned D_W = OFFSET_BITS + 1;

  logic [dad_pkg::YEAR_W-1:0]  year_q, year_d;
  logic [dad_pkg::MONTH_W-1:0] month_q, month_d;
  logic [D_W-1:0]              day_q, day_d;
  logic [dad_pkg::YMOD_W-1:0]  ymod_q, ymod_d;
  logic [dad_pkg::RED_W-1:0]   red_q, red_d;

  logic                        leap;
  logic [dad_pkg::DAY_W-1:0]   len;
  logic                        day_gt;
  logic [dad_pkg::MONTH_W-1:0] month_clamp;
  logic [dad_pkg::RED_W:0]     div_base, div_shift;
  logic [dad_pkg::RED_W-1:0]   red_next;
  logic [dad_pkg::YMOD_W-1:0]  yy;
  logic [1:0]                  cent;
  logic [dad_pkg::WSUM_W-1:0]  wsum;

  // The leap rule only needs the year modulo 400.
  assign leap = (ymod_q[1:0] == 2'd0) && (ymod_q != 9'd100) && (ymod_q != 9'd200)
                && (ymod_q != 9'd300);
  assign len    = dad_pkg::days_in(month_q, leap);
  assign day_gt = day_q > D_W'(len);
  assign sts_o.walk_done = !day_gt;

  always_comb begin
    month_clamp = base_month_i;
    if (base_month_i == '0) begin
      month_clamp = dad_pkg::MONTH_W'(1);
    end else if (base_month_i > dad_pkg::MONTH_W'(dad_pkg::MONTHS)) begin
      month_clamp = dad_pkg::MONTH_W'(dad_pkg::MONTHS);
    end
  end

  // Restoring compare-subtract step, shared by the year and weekday reductions.
  assign div_base  = cmd_i.red_week ? (dad_pkg::RED_W + 1)'(dad_pkg::WEEK_LEN)
                                    : (dad_pkg::RED_W + 1)'(dad_pkg::YEAR_MOD);
  assign div_shift = div_base << cmd_i.red_shift;
  assign red_next  = ({1'b0, red_q} >= div_shift) ? red_q - div_shift[dad_pkg::RED_W-1:0]
                                                 : red_q;

  // Weekday sum on the March-based year, taken modulo 400.
  always_comb begin
    yy = ymod_q;
    if (month_q <= dad_pkg::MONTH_W'(dad_pkg::FEB)) begin
      yy = (ymod_q == '0) ? dad_pkg::YMOD_W'(dad_pkg::YEAR_MOD - 1) : ymod_q - 9'd1;
    end
    priority if (yy >= 9'd300) begin
      cent = 2'd3;
    end else if (yy >= 9'd200) begin
      cent = 2'd2;
    end else if (yy >= 9'd100) begin
      cent = 2'd1;
    end else begin
      cent = 2'd0;
    end
    wsum = dad_pkg::WSUM_W'(day_q[dad_pkg::DAY_W-1:0])
         + dad_pkg::WSUM_W'(dad_pkg::month_code(month_q))
         + dad_pkg::WSUM_W'(yy)
         + dad_pkg::WSUM_W'(yy[dad_pkg::YMOD_W-1:2])
         - dad_pkg::WSUM_W'(cent);
  end

  always_comb begin
    year_d  = year_q;
    month_d = month_q;
    day_d   = day_q;
    ymod_d  = ymod_q;
    red_d   = red_q;
    if (cmd_i.load) begin
      year_d  = base_year_i;
      month_d = month_clamp;
      day_d   = D_W'(base_day_i) + D_W'(day_offset_i);
      red_d   = dad_pkg::RED_W'(base_year_i);
    end
    if (cmd_i.red_en) begin
      red_d = red_next;
    end
    if (cmd_i.ymod_ld) begin
      ymod_d = red_next[dad_pkg::YMOD_W-1:0];
    end
    if (cmd_i.walk && day_gt) begin
      day_d = day_q - D_W'(len);
      if (month_q == dad_pkg::MONTH_W'(dad_pkg::MONTHS)) begin
        month_d = dad_pkg::MONTH_W'(1);
        year_d  = year_q + dad_pkg::YEAR_W'(1);
        ymod_d  = (ymod_q == dad_pkg::YMOD_W'(dad_pkg::YEAR_MOD - 1)) ? '0
                                                                      : ymod_q + 9'd1;
      end else begin
        month_d = month_q + dad_pkg::MONTH_W'(1);
      end
    end
    if (cmd_i.wsum) begin
      red_d = dad_pkg::RED_W'(wsum);
    end
  end

  always_ff @(posedge clk_i) begin
    year_q  <= year_d;
    month_q <= month_d;
    day_q   <= day_d;
    ymod_q  <= ymod_d;
    red_q   <= red_d;
  end

  assign year_o  = year_q;
  assign month_o = month_q;
  assign day_o   = day_q[dad_pkg::DAY_W-1:0];
  assign wday_o  = red_q[dad_pkg::WDAY_W-1:0];

endmodule

[rtl/dad_ctrl.sv]
module dad_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic             out_free_i,
  output logic             out_load_o,
  output dad_pkg::dp_cmd_t cmd_o,
  input  dad_pkg::dp_sts_t sts_i
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_YMOD,
    ST_WALK,
    ST_WSUM,
    ST_WMOD,
    ST_DONE
  } state_e;

  state_e                          state_q;
  logic [dad_pkg::RED_SHIFT_W-1:0] shift_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      shift_q <= '0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            state_q <= ST_YMOD;
            shift_q <= dad_pkg::RED_SHIFT_W'(dad_pkg::RED_START_YEAR);
          end
        end
        ST_YMOD: begin
          if (shift_q == '0) begin
            state_q <= ST_WALK;
          end else begin
            shift_q <= shift_q - 3'd1;
          end
        end
        ST_WALK: begin
          if (sts_i.walk_done) begin
            state_q <= ST_WSUM;
          end
        end
        ST_WSUM: begin
          state_q <= ST_WMOD;
          shift_q <= dad_pkg::RED_SHIFT_W'(dad_pkg::RED_START_WEEK);
        end
        ST_WMOD: begin
          if (shift_q == '0) begin
            state_q <= ST_DONE;
          end else begin
            shift_q <= shift_q - 3'd1;
          end
        end
        ST_DONE: begin
          if (out_free_i) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    out_load_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_YMOD: begin
        cmd_o.red_en    = 1'b1;
        cmd_o.red_shift = shift_q;
        // The last reduction step lands directly in the year-mod register.
        cmd_o.ymod_ld   = (shift_q == '0);
      end
      ST_WALK: begin
        cmd_o.walk = 1'b1;
      end
      ST_WSUM: begin
        cmd_o.wsum = 1'b1;
      end
      ST_WMOD: begin
        cmd_o.red_en    = 1'b1;
        cmd_o.red_week  = 1'b1;
        cmd_o.red_shift = shift_q;
      end
      ST_DONE: begin
        out_load_o = out_free_i;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

[rtl/date_add_days_weekday.sv]
// Channel | Dir | Payload                                        | Handshake
// req_i   | in  | day_offset                                     | valid/ready
// rsp_o   | out | result_year, result_month, result_day, weekday | valid/ready
// cfg     | in  | cfg_idx_i, cfg_data_i                          | cfg_we_i, no wait
//
// The month walker steps over one month per cycle, up to about 2150 months for a
// 16-bit offset. Compare-subtract steps reduce the year modulo 400 before the walk
// and the weekday sum after it.
// Requests are worked one at a time; the next one is taken once the result
// sits in the output register, which holds it while the sink stalls.
// Reset sets the base date to 2000-01-01 and empties the output register.
module date_add_days_weekday #(
  parameter int unsigned OFFSET_BITS = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [dad_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [dad_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  dad_in_if.sink                             req_i,
  dad_out_if.source                          rsp_o
);

  logic [dad_pkg::YEAR_W-1:0]  base_year_q;
  logic [dad_pkg::MONTH_W-1:0] base_month_q;
  logic [dad_pkg::DAY_W-1:0]   base_day_q;

  dad_pkg::dp_cmd_t cmd;
  dad_pkg::dp_sts_t sts;
  logic             out_load;
  logic             out_free;
  logic             in_ready;

  logic [dad_pkg::YEAR_W-1:0]  dp_year;
  logic [dad_pkg::MONTH_W-1:0] dp_month;
  logic [dad_pkg::DAY_W-1:0]   dp_day;
  logic [dad_pkg::WDAY_W-1:0]  dp_wday;

  logic                        out_valid_q;
  logic [dad_pkg::YEAR_W-1:0]  out_year_q;
  logic [dad_pkg::MONTH_W-1:0] out_month_q;
  logic [dad_pkg::DAY_W-1:0]   out_day_q;
  logic [dad_pkg::WDAY_W-1:0]  out_wday_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_year_q  <= dad_pkg::BASE_YEAR_RST;
      base_month_q <= dad_pkg::BASE_MONTH_RST;
      base_day_q   <= dad_pkg::BASE_DAY_RST;
    end else if (cfg_we_i) begin
      unique case (dad_pkg::cfg_idx_e'(cfg_idx_i))
        dad_pkg::CFG_BASE_YEAR:  base_year_q  <= cfg_data_i[dad_pkg::YEAR_W-1:0];
        dad_pkg::CFG_BASE_MONTH: base_month_q <= cfg_data_i[dad_pkg::MONTH_W-1:0];
        dad_pkg::CFG_BASE_DAY:   base_day_q   <= cfg_data_i[dad_pkg::DAY_W-1:0];
        default: ;
      endcase
    end
  end

  dad_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (in_ready),
    .out_free_i (out_free),
    .out_load_o (out_load),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  dad_dpath #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_dpath (
    .clk_i        (clk_i),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .base_year_i  (base_year_q),
    .base_month_i (base_month_q),
    .base_day_i   (base_day_q),
    .day_offset_i (req_i.day_offset),
    .year_o       (dp_year),
    .month_o      (dp_month),
    .day_o        (dp_day),
    .wday_o       (dp_wday)
  );

  assign req_i.ready = in_ready;
  assign out_free    = !out_valid_q || rsp_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_year_q  <= dp_year;
      out_month_q <= dp_month;
      out_day_q   <= dp_day;
      out_wday_q  <= dp_wday;
    end
  end

  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.result_year  = out_year_q;
  assign rsp_o.result_month = out_month_q;
  assign rsp_o.result_day   = out_day_q;
  assign rsp_o.weekday      = out_wday_q;

endmodule

[rtl/dad_checker.sv]
`include "assert_macros.svh"

module dad_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          req_valid_i,
  input logic                          req_ready_i,
  input logic                          rsp_valid_i,
  input logic                          rsp_ready_i,
  input logic [dad_pkg::YEAR_W-1:0]    rsp_year_i,
  input logic [dad_pkg::MONTH_W-1:0]   rsp_month_i,
  input logic [dad_pkg::DAY_W-1:0]     rsp_day_i,
  input logic [dad_pkg::WDAY_W-1:0]    rsp_wday_i
);

  // The month walker never leaves January through December.
  `DAD_ASSERT_IMPL(a_month_range, clk_i, rst_ni, rsp_valid_i, (rsp_month_i != '0) && (rsp_month_i <= dad_pkg::MONTH_W'(dad_pkg::MONTHS)), "result month out of range")

  `DAD_ASSERT_IMPL(a_weekday_range, clk_i, rst_ni, rsp_valid_i, rsp_wday_i < dad_pkg::WDAY_W'(dad_pkg::WEEK_LEN), "weekday not reduced mod 7")

  // Only one request is in flight at a time.
  `DAD_ASSERT_NEXT(a_one_in_flight, clk_i, rst_ni, req_valid_i && req_ready_i, !req_ready_i, "request taken while another is in flight")

  `DAD_ASSERT_NEXT(a_rsp_hold, clk_i, rst_ni, rsp_valid_i && !rsp_ready_i, rsp_valid_i && $stable(rsp_year_i) && $stable(rsp_month_i) && $stable(rsp_day_i) && $stable(rsp_wday_i), "stalled result changed")

endmodule

bind date_add_days_weekday dad_checker u_dad_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .req_valid_i (req_i.valid),
  .req_ready_i (req_i.ready),
  .rsp_valid_i (rsp_o.valid),
  .rsp_ready_i (rsp_o.ready),
  .rsp_year_i  (rsp_o.result_year),
  .rsp_month_i (rsp_o.result_month),
  .rsp_day_i   (rsp_o.result_day),
  .rsp_wday_i  (rsp_o.weekday)
);
